// ----- hdl/cqe_pkg.sv -----
// shared types and constants for the csv field quote encoder
package cqe_pkg;

    // field buffer sizing
    localparam int MAX_FIELD = 16;
    localparam int LEN_W     = $clog2(MAX_FIELD + 1);
    localparam int IDX_W     = (MAX_FIELD > 1) ? $clog2(MAX_FIELD) : 1;

    // character codes
    localparam logic [7:0] CH_QUOTE = 8'd34;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_COMMA = 8'd44;

    // input kind codes
    localparam logic [1:0] KIND_CHAR      = 2'd0;
    localparam logic [1:0] KIND_FIELD_END = 2'd1;
    localparam logic [1:0] KIND_ROW_END   = 2'd2;

    // command opcodes between front and back
    typedef enum logic [1:0] {
        OP_CHAR  = 2'd0,
        OP_FIELD = 2'd1,
        OP_ROW   = 2'd2
    } t_op;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_byte;
        logic       strip_sp;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       overflow;
    } t_out_item;

    typedef struct packed {
        t_op        op;
        logic [7:0] ch;
        logic       trim;
    } t_cmd;

endpackage

// ----- hdl/csv_field_quote_encoder_core.sv -----
// Flow, back end idle and no stalls: a character beat is written to the command queue and then to
// the field buffer when the back end takes it; a field end scans the kept characters for quoting
// before its first byte is pushed to the result queue, and a row end pushes its LF from ST_ROW.
// Throughput: one character beat per cycle while the back end is idle; a field end holds the back
// end for a quote scan, then for emission, each reading every character through the one read port.
// Reset: synchronous active low; clears queues, length, flags, delimiter to comma, not the buffer.
module csv_field_quote_encoder_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  cqe_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output cqe_pkg::t_out_item o_result,
    input  logic               i_cfg_wr_en,
    input  logic [7:0]         i_cfg_wr_data
);
    import cqe_pkg::*;

    logic       r_delim;
    logic [7:0] r_delim_byte;
    logic       w_cmd_valid;
    t_cmd       w_cmd;
    logic       w_cmd_pop;
    logic       w_res_push;
    t_out_item  w_res;
    logic       w_res_full;

    // delimiter register; a quote is replaced by a comma
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim      <= 1'b0;
            r_delim_byte <= CH_COMMA;
        end else if (i_cfg_wr_en) begin
            r_delim      <= 1'b1;
            r_delim_byte <= (i_cfg_wr_data == CH_QUOTE) ? CH_COMMA : i_cfg_wr_data;
        end
    end

    cqe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_item      (i_item),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    cqe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .i_delim     (r_delim_byte),
        .o_res_push  (w_res_push),
        .o_res       (w_res),
        .i_res_full  (w_res_full)
    );

    cqe_result_q u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_item  (w_res),
        .o_full  (w_res_full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_item  (o_result)
    );

    // delimiter byte must be a legal separator once written
    a_delim_not_quote: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_delim_byte != CH_QUOTE)
        else $error("delimiter holds a quote");

    a_delim_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_wr_en && i_cfg_wr_data != CH_QUOTE) |=>
            r_delim && r_delim_byte == $past(i_cfg_wr_data))
        else $error("delimiter write lost");

    a_delim_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cfg_wr_en |=> $stable(r_delim_byte))
        else $error("delimiter changed without a write");

endmodule

// ----- hdl/cqe_front.sv -----
// front end: accepts input beats, decodes them into commands, two-entry command queue
module cqe_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  cqe_pkg::t_in_item i_item,
    output logic              o_cmd_valid,
    output cqe_pkg::t_cmd     o_cmd,
    input  logic              i_cmd_pop
);
    import cqe_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       w_accept;
    logic       w_keep;
    logic       w_pop;
    t_cmd       w_cmd;

    // decode the beat kind into a command; unused kind is dropped here
    always_comb begin
        w_cmd.ch   = i_item.char_byte;
        w_cmd.trim = i_item.strip_sp;
        w_cmd.op   = OP_CHAR;
        w_keep     = 1'b1;
        unique case (i_item.kind)
            KIND_CHAR:      w_cmd.op = OP_CHAR;
            KIND_FIELD_END: w_cmd.op = OP_FIELD;
            KIND_ROW_END:   w_cmd.op = OP_ROW;
            default:        w_keep   = 1'b0;
        endcase
    end

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_accept    = i_push && !o_full && w_keep;
    assign w_pop       = i_cmd_pop && o_cmd_valid;
    assign n_cnt       = r_cnt + {1'b0, w_accept} - {1'b0, w_pop};

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_accept) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_q[r_wp] <= w_cmd;
        end
    end

endmodule

// ----- hdl/cqe_back.sv -----
// back end: field buffer, quote scan and byte emission sequencer
module cqe_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  cqe_pkg::t_cmd      i_cmd,
    output logic               o_cmd_pop,
    input  logic [7:0]         i_delim,
    output logic               o_res_push,
    output cqe_pkg::t_out_item o_res,
    input  logic               i_res_full
);
    import cqe_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE     = 11'b000_0000_0001,
        ST_SCAN_RD  = 11'b000_0000_0010,
        ST_SCAN_CHK = 11'b000_0000_0100,
        ST_DELIM    = 11'b000_0000_1000,
        ST_OPENQ    = 11'b000_0001_0000,
        ST_CH_RD    = 11'b000_0010_0000,
        ST_CH_CHK   = 11'b000_0100_0000,
        ST_CH_OUT   = 11'b000_1000_0000,
        ST_CLOSEQ   = 11'b001_0000_0000,
        ST_ROW      = 11'b010_0000_0000,
        ST_DONE     = 11'b100_0000_0000
    } t_state;

    t_state           r_state,    n_state;
    logic [LEN_W-1:0] r_len,      n_len;
    logic [LEN_W-1:0] r_lead,     n_lead;
    logic [LEN_W-1:0] r_last_ns,  n_last_ns;
    logic             r_first_sp, n_first_sp;
    logic             r_last_sp,  n_last_sp;
    logic             r_drop,     n_drop;
    logic             r_first,    n_first;
    logic [LEN_W-1:0] r_ptr,      n_ptr;
    logic [LEN_W-1:0] r_lo,       n_lo;
    logic [LEN_W-1:0] r_hi,       n_hi;
    logic             r_quote,    n_quote;
    logic [7:0]       r_rd;
    logic [7:0]       r_field_mem [MAX_FIELD];

    logic             w_wr_en;
    logic             w_rd_en;
    logic             w_can;
    logic [LEN_W-1:0] w_lo;
    logic [LEN_W-1:0] w_hi;
    logic             w_spq;
    logic [LEN_W-1:0] w_ptr_nx;
    logic [LEN_W-1:0] w_len_nx;
    logic             w_ch_sp;
    logic             w_special;
    t_state           w_after_delim;

    assign w_can     = !i_res_full;
    assign w_ptr_nx  = r_ptr + LEN_W'(1);
    assign w_len_nx  = r_len + LEN_W'(1);
    assign w_ch_sp   = (i_cmd.ch == CH_SPACE);
    assign w_special = (r_rd == CH_QUOTE) || (r_rd == i_delim) ||
                       (r_rd == CH_CR) || (r_rd == CH_LF);

    // field bounds after optional trim, and quoting forced by edge spaces
    always_comb begin
        w_lo  = '0;
        w_hi  = r_len;
        w_spq = (r_len != '0) && (r_first_sp || r_last_sp);
        if (i_cmd.trim) begin
            w_spq = 1'b0;
            if (r_last_ns == '0) begin
                w_hi = '0;
            end else begin
                w_lo = r_lead;
                w_hi = r_last_ns;
            end
        end
    end

    // what follows the delimiter slot
    always_comb begin
        if (r_quote) begin
            w_after_delim = ST_OPENQ;
        end else if (r_hi > r_lo) begin
            w_after_delim = ST_CH_RD;
        end else begin
            w_after_delim = ST_DONE;
        end
    end

    // sequencer next state and emission
    always_comb begin
        n_state    = r_state;
        n_len      = r_len;
        n_lead     = r_lead;
        n_last_ns  = r_last_ns;
        n_first_sp = r_first_sp;
        n_last_sp  = r_last_sp;
        n_drop     = r_drop;
        n_first    = r_first;
        n_ptr      = r_ptr;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_quote    = r_quote;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = '{out_byte: r_rd, last_of_run: 1'b0, overflow: r_drop};
        w_wr_en    = 1'b0;
        w_rd_en    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.op)
                        OP_CHAR: begin
                            if (r_len < LEN_W'(MAX_FIELD)) begin
                                w_wr_en   = 1'b1;
                                n_len     = w_len_nx;
                                n_last_sp = w_ch_sp;
                                if (r_len == '0) begin
                                    n_first_sp = w_ch_sp;
                                end
                                if (!w_ch_sp) begin
                                    n_last_ns = w_len_nx;
                                    if (r_last_ns == '0) begin
                                        n_lead = r_len;
                                    end
                                end
                            end else begin
                                n_drop = 1'b1;
                            end
                        end
                        OP_FIELD: begin
                            n_lo    = w_lo;
                            n_hi    = w_hi;
                            n_ptr   = w_lo;
                            n_quote = w_spq;
                            n_state = (w_hi > w_lo) ? ST_SCAN_RD : ST_DELIM;
                        end
                        OP_ROW: begin
                            n_state = ST_ROW;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN_RD: begin
                w_rd_en = 1'b1;
                n_state = ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
                if (w_special) begin
                    n_quote = 1'b1;
                end
                if (w_ptr_nx == r_hi) begin
                    n_ptr   = r_lo;
                    n_state = ST_DELIM;
                end else begin
                    n_ptr   = w_ptr_nx;
                    n_state = ST_SCAN_RD;
                end
            end
            ST_DELIM: begin
                if (r_first) begin
                    n_state = w_after_delim;
                end else if (w_can) begin
                    o_res_push        = 1'b1;
                    o_res.out_byte    = i_delim;
                    o_res.last_of_run = (r_lo == r_hi);
                    n_state           = w_after_delim;
                end
            end
            ST_OPENQ: begin
                if (w_can) begin
                    o_res_push     = 1'b1;
                    o_res.out_byte = CH_QUOTE;
                    n_state        = ST_CH_RD;
                end
            end
            ST_CH_RD: begin
                w_rd_en = 1'b1;
                n_state = ST_CH_CHK;
            end
            ST_CH_CHK: begin
                // a quote inside a quoted field is doubled
                if (r_quote && (r_rd == CH_QUOTE)) begin
                    if (w_can) begin
                        o_res_push     = 1'b1;
                        o_res.out_byte = CH_QUOTE;
                        n_state        = ST_CH_OUT;
                    end
                end else begin
                    n_state = ST_CH_OUT;
                end
            end
            ST_CH_OUT: begin
                if (w_can) begin
                    o_res_push        = 1'b1;
                    o_res.last_of_run = !r_quote && (w_ptr_nx == r_hi);
                    if (w_ptr_nx == r_hi) begin
                        n_state = r_quote ? ST_CLOSEQ : ST_DONE;
                    end else begin
                        n_ptr   = w_ptr_nx;
                        n_state = ST_CH_RD;
                    end
                end
            end
            ST_CLOSEQ: begin
                if (w_can) begin
                    o_res_push        = 1'b1;
                    o_res.out_byte    = CH_QUOTE;
                    o_res.last_of_run = 1'b1;
                    n_state           = ST_DONE;
                end
            end
            ST_ROW: begin
                if (w_can) begin
                    o_res_push        = 1'b1;
                    o_res.out_byte    = CH_LF;
                    o_res.last_of_run = 1'b1;
                    o_res.overflow    = 1'b0;
                    n_first           = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            ST_DONE: begin
                n_len      = '0;
                n_lead     = '0;
                n_last_ns  = '0;
                n_first_sp = 1'b0;
                n_last_sp  = 1'b0;
                n_drop     = 1'b0;
                n_first    = 1'b0;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_len      <= '0;
            r_lead     <= '0;
            r_last_ns  <= '0;
            r_first_sp <= 1'b0;
            r_last_sp  <= 1'b0;
            r_drop     <= 1'b0;
            r_first    <= 1'b1;
            r_ptr      <= '0;
            r_lo       <= '0;
            r_hi       <= '0;
            r_quote    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_len      <= n_len;
            r_lead     <= n_lead;
            r_last_ns  <= n_last_ns;
            r_first_sp <= n_first_sp;
            r_last_sp  <= n_last_sp;
            r_drop     <= n_drop;
            r_first    <= n_first;
            r_ptr      <= n_ptr;
            r_lo       <= n_lo;
            r_hi       <= n_hi;
            r_quote    <= n_quote;
        end
    end

    // field buffer, one write port and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_field_mem[r_len[IDX_W-1:0]] <= i_cmd.ch;
        end
        if (w_rd_en) begin
            r_rd <= r_field_mem[r_ptr[IDX_W-1:0]];
        end
    end

    // checks
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(MAX_FIELD))
        else $error("field length beyond buffer size");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full)
        else $error("result beat pushed into full queue");

    a_row_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROW && o_res_push) |=> (r_first && r_state == ST_IDLE))
        else $error("end of row did not restart the row");

    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && o_res.last_of_run && r_state != ST_ROW) |=> r_state == ST_DONE)
        else $error("last beat of a field not followed by field wrap-up");

endmodule

// ----- hdl/cqe_result_q.sv -----
// two-entry result queue between the sequencer and the output port
module cqe_result_q (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  cqe_pkg::t_out_item i_item,
    output logic               o_full,
    output logic               o_empty,
    input  logic               i_pop,
    output cqe_pkg::t_out_item o_item
);
    import cqe_pkg::*;

    t_out_item  r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_item  = r_q[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign n_cnt   = r_cnt + {1'b0, w_push} - {1'b0, w_pop};

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= i_item;
        end
    end

endmodule

// ----- dv/tb.sv -----
// self-checking testbench for the csv field quote encoder core
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cqe_pkg::*;

    localparam int SETTLE_CYCLES = 200;

    // clock, reset and block ports
    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       push          = 1'b0;
    logic       full;
    t_in_item   i_item        = '0;
    logic       empty;
    logic       pop           = 1'b0;
    t_out_item  o_result;
    logic       i_cfg_wr_en   = 1'b0;
    logic [7:0] i_cfg_wr_data = 8'd0;

    // idling controls for the current phase, in percent of cycles
    int gap_pct   = 0;
    int stall_pct = 0;
    int failures  = 0;

    // encoder state kept by the predictor
    logic [7:0]  field_chars [MAX_FIELD];
    int          buf_len         = 0;
    bit          at_row_start    = 1'b1;
    bit          field_truncated = 1'b0;
    logic [7:0]  cur_delimiter   = CH_COMMA;
    t_out_item   csv_bytes_due [$];

    csv_field_quote_encoder_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_item        (i_item),
        .empty         (empty),
        .pop           (pop),
        .o_result      (o_result),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always #5 i_clk = ~i_clk;

    // queue one expected output byte
    function automatic void emit_byte(input logic [7:0] b, input logic ovf);
        t_out_item r;
        r.out_byte    = b;
        r.last_of_run = 1'b0;
        r.overflow    = ovf;
        csv_bytes_due = {csv_bytes_due, r};
    endfunction

    // predict the csv bytes caused by one accepted beat
    function automatic void encode_item(input t_in_item it);
        int   lo;
        int   hi;
        int   emitted;
        bit   quoted;
        logic ovf;
        lo      = 0;
        hi      = buf_len;
        emitted = 0;
        quoted  = 1'b0;
        ovf     = field_truncated;
        case (it.kind)
            KIND_CHAR: begin
                if (buf_len < MAX_FIELD) begin
                    field_chars[buf_len] = it.char_byte;
                    buf_len++;
                end else begin
                    field_truncated = 1'b1;
                end
            end
            KIND_FIELD_END: begin
                if (hi > MAX_FIELD) hi = MAX_FIELD;
                // strip spaces on both ends
                if (it.strip_sp) begin
                    while (lo < hi && field_chars[lo] == CH_SPACE) lo++;
                    while (hi > lo && field_chars[hi-1] == CH_SPACE) hi--;
                end
                // quoting decision, empty fields stay bare
                if (hi > lo) begin
                    for (int i = lo; i < hi; i++) begin
                        if (field_chars[i] == CH_QUOTE || field_chars[i] == cur_delimiter ||
                            field_chars[i] == CH_CR || field_chars[i] == CH_LF)
                            quoted = 1'b1;
                    end
                    if (field_chars[lo] == CH_SPACE || field_chars[hi-1] == CH_SPACE)
                        quoted = 1'b1;
                end
                if (!at_row_start) begin
                    emit_byte(cur_delimiter, ovf);
                    emitted++;
                end
                if (quoted) begin
                    emit_byte(CH_QUOTE, ovf);
                    emitted++;
                end
                for (int i = lo; i < hi; i++) begin
                    if (quoted && field_chars[i] == CH_QUOTE) begin
                        emit_byte(CH_QUOTE, ovf);
                        emitted++;
                    end
                    emit_byte(field_chars[i], ovf);
                    emitted++;
                end
                if (quoted) begin
                    emit_byte(CH_QUOTE, ovf);
                    emitted++;
                end
                if (emitted > 0)
                    csv_bytes_due[csv_bytes_due.size()-1].last_of_run = 1'b1;
                at_row_start    = 1'b0;
                buf_len         = 0;
                field_truncated = 1'b0;
            end
            KIND_ROW_END: begin
                emit_byte(CH_LF, 1'b0);
                csv_bytes_due[csv_bytes_due.size()-1].last_of_run = 1'b1;
                at_row_start = 1'b1;
            end
            default: begin
            end
        endcase
    endfunction

    function automatic t_in_item beat_of(input logic [1:0] kind, input logic [7:0] ch,
                                         input logic trim);
        t_in_item it;
        it.kind      = kind;
        it.char_byte = ch;
        it.strip_sp  = trim;
        return it;
    endfunction

    // character source weighted toward the bytes that force quoting
    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 9))
            0:       return CH_SPACE;
            1:       return CH_QUOTE;
            2:       return cur_delimiter;
            3:       return CH_CR;
            4:       return CH_LF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // offer one input beat and predict it once accepted
    task automatic send_item(input t_in_item it);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < gap_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        encode_item(it);
    endtask

    // stop sending, wait for every expected byte, then let the block settle
    task automatic drain_results();
        @(negedge i_clk);
        push <= 1'b0;
        while (csv_bytes_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // delimiter write, only with the block idle
    task automatic set_delimiter(input logic [7:0] value);
        drain_results();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        cur_delimiter = (value == CH_QUOTE) ? CH_COMMA : value;
    endtask

    // receiver side: random stalls per phase
    always @(negedge i_clk) begin
        pop <= ($urandom_range(0, 99) >= stall_pct);
    end

    // compare each popped beat with the oldest expected byte
    always @(posedge i_clk) begin : check_beats
        t_out_item want;
        if (i_rst_n && pop && !empty) begin
            if (csv_bytes_due.size() == 0) begin
                $error("unexpected beat: out_byte %0h last_of_run %0b overflow %0b",
                       o_result.out_byte, o_result.last_of_run, o_result.overflow);
                failures++;
            end else begin
                want = csv_bytes_due.pop_front();
                if (o_result.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %0h, actual %0h",
                           want.out_byte, o_result.out_byte);
                    failures++;
                end
                if (o_result.last_of_run !== want.last_of_run) begin
                    $error("last_of_run: expected %0b, actual %0b",
                           want.last_of_run, o_result.last_of_run);
                    failures++;
                end
                if (o_result.overflow !== want.overflow) begin
                    $error("overflow: expected %0b, actual %0b",
                           want.overflow, o_result.overflow);
                    failures++;
                end
            end
        end
    end

    // empty first field, all-space field trimmed away, trimmed inner text
    task automatic test_empty_and_trim();
        send_item(beat_of(KIND_FIELD_END, 8'($urandom), 1'b0));
        send_item(beat_of(KIND_CHAR, CH_SPACE, 1'b0));
        send_item(beat_of(KIND_CHAR, CH_SPACE, 1'b1));
        send_item(beat_of(KIND_FIELD_END, 8'($urandom), 1'b1));
        send_item(beat_of(KIND_CHAR, CH_SPACE, 1'b0));
        send_item(beat_of(KIND_CHAR, "q", 1'b0));
        send_item(beat_of(KIND_CHAR, CH_SPACE, 1'b0));
        send_item(beat_of(KIND_FIELD_END, 8'($urandom), 1'b1));
    endtask

    // row end with a field still open, then that field ended at row start and the row ended
    task automatic test_row_end_pending();
        send_item(beat_of(KIND_CHAR, "a", 1'b1));
        send_item(beat_of(KIND_ROW_END, 8'($urandom), 1'b1));
        send_item(beat_of(KIND_FIELD_END, 8'($urandom), 1'b0));
        send_item(beat_of(KIND_ROW_END, 8'($urandom), 1'b0));
    endtask

    // full buffer of special and plain bytes plus one dropped character
    task automatic test_overflow_field();
        logic [7:0] text [17] = '{CH_SPACE, CH_QUOTE, CH_CR, CH_LF, CH_COMMA, 8'h00, 8'hFF,
                                  "a", "b", "c", "d", "e", "f", "g", "h", CH_SPACE, "z"};
        foreach (text[i]) send_item(beat_of(KIND_CHAR, text[i], 1'($urandom)));
        send_item(beat_of(KIND_FIELD_END, 8'($urandom), 1'b0));
    endtask

    // random rows of fields with noise, pausing once to let the output drain
    task automatic test_random_traffic(input int sender_gap, input int receiver_stall,
                                       input logic [7:0] delim, input int beat_goal);
        int sent;
        int len;
        bit paused;
        sent   = 0;
        paused = 1'b0;
        set_delimiter(delim);
        gap_pct   = sender_gap;
        stall_pct = receiver_stall;
        while (sent < beat_goal) begin
            if ($urandom_range(0, 99) < 8) begin
                // stray field or row end
                send_item(beat_of(($urandom_range(0, 1) != 0) ? KIND_ROW_END : KIND_FIELD_END,
                                  8'($urandom), 1'($urandom)));
                sent++;
            end else begin
                len = ($urandom_range(0, 99) < 12) ? $urandom_range(MAX_FIELD + 1, MAX_FIELD + 4)
                                                   : $urandom_range(0, 9);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 99) < 4) begin
                        send_item(beat_of(KIND_ROW_END, 8'($urandom), 1'($urandom)));
                        sent++;
                    end
                    send_item(beat_of(KIND_CHAR, pick_char(), 1'($urandom)));
                    sent++;
                end
                send_item(beat_of(KIND_FIELD_END, 8'($urandom), 1'($urandom)));
                sent++;
                if ($urandom_range(0, 99) < 25) begin
                    send_item(beat_of(KIND_ROW_END, 8'($urandom), 1'($urandom)));
                    sent++;
                end
            end
            if (!paused && sent >= beat_goal / 2) begin
                drain_results();
                paused = 1'b1;
            end
        end
    endtask

    // test sequence
    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_and_trim();
        test_row_end_pending();
        test_overflow_field();
        test_random_traffic(0, 0, 8'h00, 50);
        test_random_traffic(62, 0, 8'hFF, 65);
        test_random_traffic(0, 62, CH_QUOTE, 65);
        test_random_traffic(35, 35, 8'($urandom_range(0, 255)), 65);
        test_random_traffic(0, 0, CH_SPACE, 65);
        drain_results();
        if (failures == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
